/* src/bfba_pkg.sv */
// Package: constants, beat types and control struct for the best-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 24;

    localparam int FIELD_W = 24;
    localparam int IDX_OUT_W = 6;
    localparam int CMD_W = 2;
    localparam int CHARGE_W = FIELD_W + 1;
    localparam int CMP_W = (ADDR_BITS > CHARGE_W) ? ADDR_BITS : CHARGE_W;
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [CHARGE_W-1:0]  OVERHEAD  = CHARGE_W'(3);
    localparam logic [ADDR_BITS-1:0] ADDR_BIAS = ADDR_BITS'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FIELD_W-1:0] block_offset;
        logic [FIELD_W-1:0] block_length;
        logic [FIELD_W-1:0] request_size;
    } t_in_beat;

    typedef struct packed {
        logic                 granted;
        logic [FIELD_W-1:0]   address;
        logic [IDX_OUT_W-1:0] chosen_index;
        logic [FIELD_W-1:0]   remaining;
        logic                 table_full;
    } t_out_beat;

    typedef struct packed {
        logic [ADDR_BITS-1:0] offset;
        logic [ADDR_BITS-1:0] length;
        logic [ADDR_BITS-1:0] used;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             load;
        logic [IDX_W-1:0] idx;
    } t_best_ctl;

endpackage

`default_nettype wire

/* src/bfba_table.sv */
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bfba_table
    import bfba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_entry           i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_entry                o_rd_data
);

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/bfba_best.sv */
// Shared fit comparator: tracks the tightest entry that covers the charge.
`timescale 1ns / 1ps
`default_nettype none

module bfba_best
    import bfba_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_best_ctl             i_ctl,
    input  wire t_entry                i_entry,
    input  wire logic [CHARGE_W-1:0]   i_charge,
    output logic                       o_found,
    output logic [IDX_W-1:0]           o_best_idx,
    output logic [ADDR_BITS-1:0]       o_best_free,
    output t_entry                     o_best_entry
);

    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [ADDR_BITS-1:0] r_best_free;
    t_entry               r_best_entry;
    logic [ADDR_BITS-1:0] free_sp;
    logic                 fits;
    logic                 better;

    always_comb begin
        free_sp = (i_entry.length >= i_entry.used) ? (i_entry.length - i_entry.used) : '0;
        fits    = CMP_W'(free_sp) >= CMP_W'(i_charge);
        better  = !r_found || (free_sp < r_best_free);
        n_found = r_found;
        if (i_ctl.clear) begin
            n_found = 1'b0;
        end else if (i_ctl.load && fits) begin
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.load && fits && better) begin
            r_best_idx   <= i_ctl.idx;
            r_best_free  <= free_sp;
            r_best_entry <= i_entry;
        end
    end

    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_free  = r_best_free;
    assign o_best_entry = r_best_entry;

endmodule

`default_nettype wire

/* src/best_fit_block_allocator.sv */
// Top level: command sequencer, entry count and result register of the allocator.
`timescale 1ns / 1ps
`default_nettype none

// Best-fit allocator over a table of up to MAX_BLOCKS free blocks. One command
// is worked on at a time; the input is ready only while the sequencer is idle.
// Add, clear and unknown commands, and an allocate on an empty table, go from
// idle to the done state and load their result into the output register once
// that register is free. An allocate with N entries held (N of one or more)
// reads the table one entry a cycle through the single memory read port and one
// shared comparator. After the last read come the registered read, the final
// compare and the step into the done state, and then its result is loaded in
// the same way. A finished result sits in an output register until taken; the
// next command is taken from the cycle after that result has been loaded there.
module best_fit_block_allocator
    import bfba_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_out_valid, n_out_valid;
    t_out_beat             r_out, n_out;
    t_in_beat              r_item;

    logic                  in_fire;
    logic                  done_go;
    logic                  rd_en;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    t_entry                wr_data;
    t_entry                rd_data;
    logic [CHARGE_W-1:0]   charge;
    t_best_ctl             best_ctl;
    logic                  found;
    logic [IDX_W-1:0]      best_idx;
    logic [ADDR_BITS-1:0]  best_free;
    t_entry                best_entry;

    assign in_fire = i_in_valid && o_in_ready;
    assign done_go = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign charge  = CHARGE_W'(r_item.request_size) + OVERHEAD;
    assign rd_en   = (r_state == S_SCAN) && (r_rd_idx < r_count);

    assign best_ctl.clear = in_fire;
    assign best_ctl.load  = r_cmp_vld;
    assign best_ctl.idx   = r_cmp_idx;

    bfba_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    bfba_best u_best (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (best_ctl),
        .i_entry      (rd_data),
        .i_charge     (charge),
        .o_found      (found),
        .o_best_idx   (best_idx),
        .o_best_free  (best_free),
        .o_best_entry (best_entry)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = best_idx;
        wr_data     = best_entry;
        wr_data.used = ADDR_BITS'(CMP_W'(best_entry.used) + CMP_W'(charge));

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_rd_idx = '0;
                    if ((i_in_data.command == CMD_ALLOC) && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                end else if (!r_cmp_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (done_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_item.command)
                        CMD_ADD: begin
                            if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                                n_out.table_full = 1'b1;
                            end else begin
                                wr_en          = 1'b1;
                                wr_addr        = r_count[IDX_W-1:0];
                                wr_data.offset = ADDR_BITS'(r_item.block_offset);
                                wr_data.length = ADDR_BITS'(r_item.block_length);
                                wr_data.used   = '0;
                                n_count        = r_count + CNT_W'(1);
                                n_out.granted      = 1'b1;
                                n_out.chosen_index = IDX_OUT_W'(r_count);
                                n_out.remaining    =
                                    FIELD_W'(ADDR_BITS'(r_item.block_length));
                            end
                        end
                        CMD_ALLOC: begin
                            if (found && (r_count != '0)) begin
                                wr_en              = 1'b1;
                                n_out.granted      = 1'b1;
                                n_out.address      = FIELD_W'(ADDR_BITS'(best_entry.offset
                                                     + best_entry.used + ADDR_BIAS));
                                n_out.chosen_index = IDX_OUT_W'(best_idx);
                                n_out.remaining    = FIELD_W'(CMP_W'(best_free)
                                                     - CMP_W'(charge));
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        if (in_fire) begin
            r_item <= i_in_data;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
